>>> rtl/core/psrb_pkg.sv
// Package for the per-stream sequence reorder buffer.
// Holds sizes, status and register codes, state and struct types, helpers.
// No dependencies.
package psrb_pkg;

    localparam int NUM_STREAMS = 8;
    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;

    localparam int SLOT_W  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W  = $clog2(NUM_STREAMS * QUEUE_DEPTH);
    localparam int DEPTH   = NUM_STREAMS * QUEUE_DEPTH;
    localparam int KEY_W   = 25;
    localparam int ENTRY_W = 64;

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    typedef enum logic [2:0] {
        STAT_ACCEPTED  = 3'd0,
        STAT_BAD_MAGIC = 3'd1,
        STAT_TABLE_FULL = 3'd2,
        STAT_QUEUE_FULL = 3'd3,
        STAT_NOTHING   = 3'd4,
        STAT_LONG      = 3'd5,
        STAT_SHORT     = 3'd6,
        STAT_BAD_VER   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAGIC = 2'd0,
        CFG_LONG  = 2'd1,
        CFG_SHORT = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [FILL_W-1:0] hit_fill;
        logic              free_ok;
        logic [SLOT_W-1:0] free_slot;
    } lookup_t;

    typedef struct packed {
        logic              open;
        logic              fill_we;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [FILL_W-1:0] fill;
    } tbl_upd_t;

    function automatic logic precedes(input logic [31:0] sa, input logic [31:0] sb);
        logic [31:0] d;
        d = sb - sa;
        return (sa != sb) && (d < HALF_RANGE);
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [FILL_W-1:0] idx);
        int a;
        a = int'(slot) * QUEUE_DEPTH + int'(idx[IDX_W-1:0]);
        return ADDR_W'(a);
    endfunction

endpackage

>>> rtl/core/psrb_entry_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// Holds the queued entries of all streams. No dependencies.
module psrb_entry_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/psrb_stream_table.sv
// Stream slot table: keys, valid bits and queue fill counts per slot.
// Depends on psrb_pkg.
module psrb_stream_table
    import psrb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key,
    output lookup_t          lookup,
    input  tbl_upd_t         upd
);

    logic [KEY_W-1:0]       key_reg   [NUM_STREAMS];
    logic [NUM_STREAMS-1:0] valid_reg;
    logic [FILL_W-1:0]      fill_reg  [NUM_STREAMS];

    always_comb
    begin
        lookup = '0;
        for (int s = 0; s < NUM_STREAMS; s++)
        begin
            if (!lookup.hit && valid_reg[s] && key_reg[s] == key)
            begin
                lookup.hit      = 1'b1;
                lookup.hit_slot = SLOT_W'(s);
                lookup.hit_fill = fill_reg[s];
            end
            if (!lookup.free_ok && !valid_reg[s])
            begin
                lookup.free_ok   = 1'b1;
                lookup.free_slot = SLOT_W'(s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.open)
        begin
            key_reg[upd.slot] <= upd.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            if (upd.open)
            begin
                valid_reg[upd.slot] <= 1'b1;
                fill_reg[upd.slot]  <= '0;
            end
            if (upd.fill_we)
            begin
                fill_reg[upd.slot] <= upd.fill;
            end
        end
    end

endmodule

>>> rtl/core/per_stream_sequence_reorder_buffer_core.sv
// Top level of the per-stream sequence reorder buffer: control sequencer,
// configuration registers and output register.
// Depends on psrb_pkg, psrb_stream_table and psrb_entry_ram.
//
// A push is accepted in ST_IDLE; in ST_DECIDE, once the output register is
// free, the stream is looked up and the entry filed. A drain emits one beat
// per drained entry, up to fill less min_keep and at most MAX_RESULTS; each
// scans the queue for the oldest sequence number, closes the gap at its
// position and emits it, paced by the entry RAM's single registered read port.
// A new beat is accepted only once the previous item has handed its last
// result to the output register, which may still be waiting for the sink.
module per_stream_sequence_reorder_buffer_core
    import psrb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // serial[15:0], module[24:16], seq[56:25], magic[88:57], version[104:89],
    // tag[120:105], min_keep[126:121], zero[127]
    input  logic [127:0] s_axis_tdata,
    // mode[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_seq[31:0], out_tag[47:32]
    output logic [47:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    state_t state_reg, state_next;

    logic        mode_reg;
    logic [15:0] serial_reg;
    logic [8:0]  module_reg;
    logic [31:0] seq_reg;
    logic [31:0] magic_reg;
    logic [15:0] ver_reg;
    logic [15:0] tag_reg;
    logic [5:0]  keep_reg;

    logic [31:0] exp_magic_reg;
    logic [15:0] long_ver_reg;
    logic [15:0] short_ver_reg;

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  idx_reg, idx_next;
    logic [FILL_W-1:0]  best_idx_reg, best_idx_next;
    logic [ENTRY_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   k_reg, k_next;

    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg, out_status_next;
    logic [31:0] out_seq_reg, out_seq_next;
    logic [15:0] out_tag_reg, out_tag_next;
    logic        out_last_reg, out_last_next;

    logic [KEY_W-1:0]   key;
    lookup_t            lookup;
    tbl_upd_t           upd;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic [8:0]        module_code;
    logic [SLOT_W-1:0] push_slot;
    logic [FILL_W-1:0] push_fill;
    logic [FILL_W-1:0] drain_diff;
    logic              new_best;
    logic [FILL_W-1:0] sel_idx;
    logic [15:0]       best_ver;

    psrb_stream_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key),
        .lookup (lookup),
        .upd    (upd)
    );

    psrb_entry_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_tag_reg, out_seq_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    assign module_code = mode_reg ? module_reg : module_reg + 9'd1;
    assign key         = {serial_reg, module_code};
    assign push_slot   = lookup.hit ? lookup.hit_slot : lookup.free_slot;
    assign push_fill   = lookup.hit ? lookup.hit_fill : '0;
    assign drain_diff  = lookup.hit_fill - FILL_W'(keep_reg);
    assign new_best    = (idx_reg == '0) || precedes(ram_rdata[63:32], best_reg[63:32]);
    assign sel_idx     = new_best ? idx_reg : best_idx_reg;
    assign best_ver    = best_reg[31:16];

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        upd             = '0;
        upd.key         = key;
        ram_we          = 1'b0;
        ram_waddr       = entry_addr(slot_reg, idx_reg);
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = entry_addr(slot_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!mode_reg)
                begin
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_seq_next  = '0;
                        out_tag_next  = '0;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                        priority if (magic_reg != exp_magic_reg)
                        begin
                            out_status_next = STAT_BAD_MAGIC;
                        end
                        else if (!lookup.hit && !lookup.free_ok)
                        begin
                            out_status_next = STAT_TABLE_FULL;
                        end
                        else
                        begin
                            upd.open = !lookup.hit;
                            upd.slot = push_slot;
                            if (push_fill == FILL_W'(QUEUE_DEPTH))
                            begin
                                out_status_next = STAT_QUEUE_FULL;
                            end
                            else
                            begin
                                out_status_next = STAT_ACCEPTED;
                                upd.fill_we     = 1'b1;
                                upd.fill        = push_fill + FILL_W'(1);
                                ram_we          = 1'b1;
                                ram_waddr       = entry_addr(push_slot, push_fill);
                                ram_wdata       = {seq_reg, ver_reg, tag_reg};
                            end
                        end
                    end
                end
                else if (!lookup.hit || {1'b0, lookup.hit_fill} <= 7'(keep_reg))
                begin
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_status_next = STAT_NOTHING;
                        out_seq_next    = '0;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    slot_next  = lookup.hit_slot;
                    fill_next  = lookup.hit_fill;
                    idx_next   = '0;
                    k_next     = '0;
                    n_next     = (32'(drain_diff) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS)
                                                                  : CNT_W'(drain_diff);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (new_best)
                begin
                    best_next     = ram_rdata;
                    best_idx_next = idx_reg;
                end
                if (idx_reg == fill_reg - FILL_W'(1))
                begin
                    idx_next   = sel_idx;
                    state_next = (sel_idx + FILL_W'(1) < fill_reg) ? ST_SHIFT_RD : ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = entry_addr(slot_reg, idx_reg + FILL_W'(1));
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                ram_we = 1'b1;
                if (idx_reg + FILL_W'(2) < fill_reg)
                begin
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_seq_next  = best_reg[63:32];
                    out_tag_next  = best_reg[15:0];
                    out_last_next = (k_reg == n_reg - CNT_W'(1));
                    priority if (best_ver == long_ver_reg)
                    begin
                        out_status_next = STAT_LONG;
                    end
                    else if (best_ver == short_ver_reg)
                    begin
                        out_status_next = STAT_SHORT;
                    end
                    else
                    begin
                        out_status_next = STAT_BAD_VER;
                    end
                    fill_next   = fill_reg - FILL_W'(1);
                    upd.fill_we = 1'b1;
                    upd.slot    = slot_reg;
                    upd.fill    = fill_reg - FILL_W'(1);
                    k_next      = k_reg + CNT_W'(1);
                    idx_next    = '0;
                    state_next  = (k_reg == n_reg - CNT_W'(1)) ? ST_IDLE : ST_SCAN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            exp_magic_reg <= '0;
            long_ver_reg  <= '0;
            short_ver_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_MAGIC: exp_magic_reg <= cfg_data;
                    CFG_LONG:  long_ver_reg  <= cfg_data[15:0];
                    CFG_SHORT: short_ver_reg <= cfg_data[15:0];
                    CFG_NONE:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg   <= s_axis_tuser;
            serial_reg <= s_axis_tdata[15:0];
            module_reg <= s_axis_tdata[24:16];
            seq_reg    <= s_axis_tdata[56:25];
            magic_reg  <= s_axis_tdata[88:57];
            ver_reg    <= s_axis_tdata[104:89];
            tag_reg    <= s_axis_tdata[120:105];
            keep_reg   <= s_axis_tdata[126:121];
        end
        slot_reg       <= slot_next;
        fill_reg       <= fill_next;
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_ACCEPTED || m_axis_tuser == STAT_BAD_MAGIC ||
        m_axis_tuser == STAT_TABLE_FULL || m_axis_tuser == STAT_QUEUE_FULL ||
        m_axis_tuser == STAT_NOTHING) |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("push or empty drain result not single and zeroed");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten while held");

    a_drain_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD || state_reg == ST_SCAN_CMP || state_reg == ST_EMIT) |->
        (fill_reg != '0) && (fill_reg <= FILL_W'(QUEUE_DEPTH)) && (k_reg < n_reg))
        else $error("drain running with bad fill or count");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD || state_reg == ST_SCAN_CMP) |-> !ram_we)
        else $error("entry RAM written during scan");

endmodule
